FILE: sv/bgf_pkg.sv
// Shared types and constants for the graph bridge finder.
`timescale 1ns / 1ps
package bgf_pkg;

  localparam int unsigned MaxVertices = 64;
  localparam int unsigned MaxEntries  = 256;
  localparam int unsigned VtxW        = $clog2(MaxVertices);
  localparam int unsigned EntW        = $clog2(MaxEntries);
  localparam int unsigned PtrW        = EntW + 1;
  localparam int unsigned TimeW       = VtxW + 1;
  localparam int unsigned DegW        = EntW + 1;
  localparam int unsigned TotW        = 6;
  localparam int unsigned CountW      = 7;

  localparam logic [PtrW-1:0] NoEntry  = PtrW'(MaxEntries);
  localparam logic [TotW-1:0] TotalCap = TotW'(63);

  localparam logic OpLoad      = 1'b0;
  localparam logic OpRun       = 1'b1;
  localparam logic KindBridge  = 1'b0;
  localparam logic KindTotals  = 1'b1;

  // One depth-first frame: vertex, its parent and the next list entry to scan.
  typedef struct packed {
    logic [VtxW-1:0] node;
    logic [VtxW-1:0] parent;
    logic            has_parent;
    logic [PtrW-1:0] cursor;
  } frame_t;

  typedef enum logic [13:0] {
    StIdle   = 14'b00000000000001,
    StLoad1  = 14'b00000000000010,
    StLoad2  = 14'b00000000000100,
    StRoot   = 14'b00000000001000,
    StVisit  = 14'b00000000010000,
    StStep   = 14'b00000000100000,
    StEdge   = 14'b00000001000000,
    StBack   = 14'b00000010000000,
    StPop    = 14'b00000100000000,
    StPopRd  = 14'b00001000000000,
    StPopCmp = 14'b00010000000000,
    StPopMin = 14'b00100000000000,
    StEmit   = 14'b01000000000000,
    StTotals = 14'b10000000000000
  } state_e;

endpackage

FILE: sv/bgf_ram.sv
// Generic single-write, single-read memory with registered read data.
`timescale 1ns / 1ps
module bgf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: sv/bgf_cmp.sv
// Shared time and index comparator: less-than flag and minimum.
`timescale 1ns / 1ps
module bgf_cmp (
  input  logic [bgf_pkg::TimeW-1:0] a_i,
  input  logic [bgf_pkg::TimeW-1:0] b_i,
  output logic                      lt_o,
  output logic [bgf_pkg::TimeW-1:0] min_o
);

  assign lt_o  = (a_i < b_i);
  assign min_o = lt_o ? a_i : b_i;

endmodule

FILE: sv/graph_bridge_finder_unit.sv
// Top level of the graph bridge finder: sequencer, graph memories and result register.
`timescale 1ns / 1ps
// A load transaction starts a new list in StLoad1 or extends one through StLoad2; a full store drops it.
// A run scans adjacency entries (StStep, StEdge, and StBack for a back edge), visits and pops vertices,
// tries each root candidate below the count, and emits each bridge and then the totals transaction;
// this order of states follows from the single read port of each memory and the one shared comparator.
// Throughput: one transaction at a time; in_ready_o is high only when the sequencer idles.
// Reset: rst_ni clears all lists, counts and flags at once through per-vertex valid bits.
module graph_bridge_finder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       operation_i,
  input  logic [5:0] vertex_i,
  input  logic [5:0] neighbor_i,
  input  logic [6:0] vertex_count_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       kind_o,
  output logic [5:0] end_low_o,
  output logic [5:0] end_high_o,
  output logic [5:0] bridge_total_o,
  output logic [5:0] nonleaf_total_o,
  output logic       dropped_o,
  output logic       last_o
);

  localparam int unsigned VW = bgf_pkg::VtxW;
  localparam int unsigned EW = bgf_pkg::EntW;
  localparam int unsigned PW = bgf_pkg::PtrW;
  localparam int unsigned TW = bgf_pkg::TimeW;
  localparam int unsigned DW = bgf_pkg::DegW;
  localparam int unsigned SW = bgf_pkg::TotW;
  localparam int unsigned NV = bgf_pkg::MaxVertices;
  localparam int unsigned FW = $bits(bgf_pkg::frame_t);

  // Control state.
  bgf_pkg::state_e state_q, state_d;
  logic [PW-1:0] used_q, used_d;        // entries stored so far
  logic          drop_q, drop_d;
  logic [NV-1:0] vused_q, vused_d;      // vertex has a list (head, tail, degree valid)
  logic [NV-1:0] visited_q, visited_d;  // vertex has an entry time this run
  logic [TW-1:0] n_q, n_d;              // vertex count of the run
  logic [TW-1:0] root_q, root_d;
  logic [TW-1:0] vc_q, vc_d;            // visit clock
  logic [TW-1:0] sp_q, sp_d;            // frames on the walk stack, top included
  logic [SW-1:0] bridges_q, bridges_d;
  logic [SW-1:0] nonleaf_q, nonleaf_d;
  logic          out_valid_q, out_valid_d;

  // Datapath registers.
  bgf_pkg::frame_t top_q, top_d;        // the top frame lives in flops
  logic [VW-1:0] ld_v_q, ld_v_d, ld_w_q, ld_w_d;
  logic [VW-1:0] nv_q, nv_d, npar_q, npar_d;
  logic          nhp_q, nhp_d;
  logic [VW-1:0] child_q, child_d;
  logic [DW-1:0] degc_q, degc_d;
  logic [TW-1:0] lowc_q, lowc_d;
  logic          bpend_q, bpend_d;

  // Result register.
  logic          out_load;
  logic          rec_kind_d, rec_kind_q, rec_drop_d, rec_drop_q, rec_last_d, rec_last_q;
  logic [VW-1:0] rec_lo_d, rec_lo_q, rec_hi_d, rec_hi_q;
  logic [SW-1:0] rec_bt_d, rec_bt_q, rec_nt_d, rec_nt_q;

  // Memory ports.
  logic          head_we, head_re, tail_we, tail_re, deg_we, deg_re;
  logic [VW-1:0] head_wa, head_ra, tail_wa, tail_ra, deg_wa, deg_ra;
  logic [EW-1:0] head_wd, head_rd, tail_wd, tail_rd;
  logic [DW-1:0] deg_wd, deg_rd;
  logic          tgt_we, tgt_re, lnk_we, lnk_re;
  logic [EW-1:0] tgt_wa, tgt_ra, lnk_wa, lnk_ra;
  logic [VW-1:0] tgt_wd, tgt_rd;
  logic [PW-1:0] lnk_wd, lnk_rd;
  logic          et_we, et_re, lt_we, lt_re, stk_we, stk_re;
  logic [VW-1:0] et_wa, et_ra, lt_wa, lt_ra, stk_wa, stk_ra;
  logic [TW-1:0] et_wd, et_rd, lt_wd, lt_rd;
  bgf_pkg::frame_t stk_wd, stk_rd;

  // Shared comparator.
  logic [TW-1:0] cmp_a, cmp_b, cmp_min;
  logic          cmp_lt;

  bgf_cmp u_cmp (.a_i(cmp_a), .b_i(cmp_b), .lt_o(cmp_lt), .min_o(cmp_min));

  bgf_ram #(.Width(EW), .Depth(NV)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_wa), .wdata_i(head_wd),
    .re_i(head_re), .raddr_i(head_ra), .rdata_o(head_rd));
  bgf_ram #(.Width(EW), .Depth(NV)) u_tail (
    .clk_i, .we_i(tail_we), .waddr_i(tail_wa), .wdata_i(tail_wd),
    .re_i(tail_re), .raddr_i(tail_ra), .rdata_o(tail_rd));
  bgf_ram #(.Width(DW), .Depth(NV)) u_deg (
    .clk_i, .we_i(deg_we), .waddr_i(deg_wa), .wdata_i(deg_wd),
    .re_i(deg_re), .raddr_i(deg_ra), .rdata_o(deg_rd));
  bgf_ram #(.Width(VW), .Depth(bgf_pkg::MaxEntries)) u_tgt (
    .clk_i, .we_i(tgt_we), .waddr_i(tgt_wa), .wdata_i(tgt_wd),
    .re_i(tgt_re), .raddr_i(tgt_ra), .rdata_o(tgt_rd));
  bgf_ram #(.Width(PW), .Depth(bgf_pkg::MaxEntries)) u_lnk (
    .clk_i, .we_i(lnk_we), .waddr_i(lnk_wa), .wdata_i(lnk_wd),
    .re_i(lnk_re), .raddr_i(lnk_ra), .rdata_o(lnk_rd));
  bgf_ram #(.Width(TW), .Depth(NV)) u_etime (
    .clk_i, .we_i(et_we), .waddr_i(et_wa), .wdata_i(et_wd),
    .re_i(et_re), .raddr_i(et_ra), .rdata_o(et_rd));
  bgf_ram #(.Width(TW), .Depth(NV)) u_ltime (
    .clk_i, .we_i(lt_we), .waddr_i(lt_wa), .wdata_i(lt_wd),
    .re_i(lt_re), .raddr_i(lt_ra), .rdata_o(lt_rd));
  bgf_ram #(.Width(FW), .Depth(NV)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_wa), .wdata_i(stk_wd),
    .re_i(stk_re), .raddr_i(stk_ra), .rdata_o(stk_rd));

  assign in_ready_o = (state_q == bgf_pkg::StIdle);

  // Degree of a vertex as the model sees it: zero when no list exists.
  logic [DW-1:0] degp_eff;
  assign degp_eff = vused_q[top_q.node] ? deg_rd : '0;

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    drop_d      = drop_q;
    vused_d     = vused_q;
    visited_d   = visited_q;
    n_d         = n_q;
    root_d      = root_q;
    vc_d        = vc_q;
    sp_d        = sp_q;
    bridges_d   = bridges_q;
    nonleaf_d   = nonleaf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    top_d       = top_q;
    ld_v_d      = ld_v_q;
    ld_w_d      = ld_w_q;
    nv_d        = nv_q;
    npar_d      = npar_q;
    nhp_d       = nhp_q;
    child_d     = child_q;
    degc_d      = degc_q;
    lowc_d      = lowc_q;
    bpend_d     = bpend_q;

    out_load   = 1'b0;
    rec_kind_d = bgf_pkg::KindBridge;
    rec_lo_d   = '0;
    rec_hi_d   = '0;
    rec_bt_d   = '0;
    rec_nt_d   = '0;
    rec_drop_d = 1'b0;
    rec_last_d = 1'b0;

    head_we = 1'b0; head_wa = '0; head_wd = '0; head_re = 1'b0; head_ra = '0;
    tail_we = 1'b0; tail_wa = '0; tail_wd = '0; tail_re = 1'b0; tail_ra = '0;
    deg_we  = 1'b0; deg_wa  = '0; deg_wd  = '0; deg_re  = 1'b0; deg_ra  = '0;
    tgt_we  = 1'b0; tgt_wa  = '0; tgt_wd  = '0; tgt_re  = 1'b0; tgt_ra  = '0;
    lnk_we  = 1'b0; lnk_wa  = '0; lnk_wd  = '0; lnk_re  = 1'b0; lnk_ra  = '0;
    et_we   = 1'b0; et_wa   = '0; et_wd   = '0; et_re   = 1'b0; et_ra   = '0;
    lt_we   = 1'b0; lt_wa   = '0; lt_wd   = '0; lt_re   = 1'b0; lt_ra   = '0;
    stk_we  = 1'b0; stk_wa  = '0; stk_wd  = top_q; stk_re = 1'b0; stk_ra  = '0;

    cmp_a = '0;
    cmp_b = '0;

    case (state_q)
      bgf_pkg::StIdle: begin
        if (in_valid_i) begin
          if (operation_i == bgf_pkg::OpRun) begin
            n_d       = (vertex_count_i > TW'(NV)) ? TW'(NV) : vertex_count_i;
            visited_d = '0;
            vc_d      = '0;
            sp_d      = '0;
            root_d    = '0;
            bridges_d = '0;
            nonleaf_d = '0;
            state_d   = bgf_pkg::StRoot;
          end else if (used_q >= PW'(bgf_pkg::MaxEntries)) begin
            // Entry store full: the transaction is dropped.
            drop_d = 1'b1;
          end else begin
            ld_v_d  = vertex_i;
            ld_w_d  = neighbor_i;
            tail_re = 1'b1;
            tail_ra = vertex_i;
            deg_re  = 1'b1;
            deg_ra  = vertex_i;
            state_d = bgf_pkg::StLoad1;
          end
        end
      end

      bgf_pkg::StLoad1: begin
        tgt_we  = 1'b1; tgt_wa  = used_q[EW-1:0]; tgt_wd = ld_w_q;
        lnk_we  = 1'b1; lnk_wa  = used_q[EW-1:0]; lnk_wd = bgf_pkg::NoEntry;
        tail_we = 1'b1; tail_wa = ld_v_q;         tail_wd = used_q[EW-1:0];
        deg_we  = 1'b1; deg_wa  = ld_v_q;
        if (vused_q[ld_v_q]) begin
          deg_wd  = deg_rd + DW'(1);
          state_d = bgf_pkg::StLoad2;
        end else begin
          deg_wd          = DW'(1);
          head_we         = 1'b1;
          head_wa         = ld_v_q;
          head_wd         = used_q[EW-1:0];
          vused_d[ld_v_q] = 1'b1;
          used_d          = used_q + PW'(1);
          state_d         = bgf_pkg::StIdle;
        end
      end

      bgf_pkg::StLoad2: begin
        lnk_we  = 1'b1;
        lnk_wa  = tail_rd;
        lnk_wd  = used_q;
        used_d  = used_q + PW'(1);
        state_d = bgf_pkg::StIdle;
      end

      bgf_pkg::StRoot: begin
        cmp_a = root_q;
        cmp_b = n_q;
        if (!cmp_lt) begin
          state_d = bgf_pkg::StTotals;
        end else if (visited_q[root_q[VW-1:0]]) begin
          root_d = root_q + TW'(1);
        end else begin
          head_re = 1'b1;
          head_ra = root_q[VW-1:0];
          nv_d    = root_q[VW-1:0];
          npar_d  = '0;
          nhp_d   = 1'b0;
          state_d = bgf_pkg::StVisit;
        end
      end

      bgf_pkg::StVisit: begin
        if (sp_q != '0) begin
          stk_we = 1'b1;
          stk_wa = VW'(sp_q - TW'(1));
        end
        top_d.node       = nv_q;
        top_d.parent     = npar_q;
        top_d.has_parent = nhp_q;
        top_d.cursor     = vused_q[nv_q] ? {1'b0, head_rd} : bgf_pkg::NoEntry;
        sp_d             = sp_q + TW'(1);
        vc_d             = vc_q + TW'(1);
        et_we = 1'b1; et_wa = nv_q; et_wd = vc_q + TW'(1);
        lt_we = 1'b1; lt_wa = nv_q; lt_wd = vc_q + TW'(1);
        visited_d[nv_q] = 1'b1;
        state_d         = bgf_pkg::StStep;
      end

      bgf_pkg::StStep: begin
        if (top_q.cursor >= PW'(bgf_pkg::MaxEntries)) begin
          state_d = bgf_pkg::StPop;
        end else begin
          tgt_re  = 1'b1;
          tgt_ra  = top_q.cursor[EW-1:0];
          lnk_re  = 1'b1;
          lnk_ra  = top_q.cursor[EW-1:0];
          state_d = bgf_pkg::StEdge;
        end
      end

      bgf_pkg::StEdge: begin
        top_d.cursor = lnk_rd;
        cmp_a        = {1'b0, tgt_rd};
        cmp_b        = n_q;
        if (!cmp_lt) begin
          state_d = bgf_pkg::StStep;
        end else if (top_q.has_parent && (tgt_rd == top_q.parent)) begin
          state_d = bgf_pkg::StStep;
        end else if (!visited_q[tgt_rd]) begin
          if (sp_q < TW'(NV)) begin
            head_re = 1'b1;
            head_ra = tgt_rd;
            nv_d    = tgt_rd;
            npar_d  = top_q.node;
            nhp_d   = 1'b1;
            state_d = bgf_pkg::StVisit;
          end else begin
            state_d = bgf_pkg::StStep;
          end
        end else begin
          et_re   = 1'b1;
          et_ra   = tgt_rd;
          lt_re   = 1'b1;
          lt_ra   = top_q.node;
          state_d = bgf_pkg::StBack;
        end
      end

      bgf_pkg::StBack: begin
        cmp_a = et_rd;
        cmp_b = lt_rd;
        if (cmp_lt) begin
          lt_we = 1'b1;
          lt_wa = top_q.node;
          lt_wd = cmp_min;
        end
        state_d = bgf_pkg::StStep;
      end

      bgf_pkg::StPop: begin
        child_d = top_q.node;
        deg_re  = 1'b1;
        deg_ra  = top_q.node;
        sp_d    = sp_q - TW'(1);
        if (sp_q == TW'(1)) begin
          root_d  = root_q + TW'(1);
          state_d = bgf_pkg::StRoot;
        end else begin
          stk_re  = 1'b1;
          stk_ra  = VW'(sp_q - TW'(2));
          state_d = bgf_pkg::StPopRd;
        end
      end

      bgf_pkg::StPopRd: begin
        top_d   = stk_rd;
        degc_d  = vused_q[child_q] ? deg_rd : '0;
        et_re   = 1'b1;
        et_ra   = stk_rd.node;
        lt_re   = 1'b1;
        lt_ra   = child_q;
        deg_re  = 1'b1;
        deg_ra  = stk_rd.node;
        state_d = bgf_pkg::StPopCmp;
      end

      bgf_pkg::StPopCmp: begin
        // Bridge when the child's low time is later than the parent's entry time.
        cmp_a   = et_rd;
        cmp_b   = lt_rd;
        lowc_d  = lt_rd;
        bpend_d = 1'b0;
        if (cmp_lt) begin
          bpend_d = (bridges_q < bgf_pkg::TotalCap);
          if (bridges_q < bgf_pkg::TotalCap) begin
            bridges_d = bridges_q + SW'(1);
          end
          if ((degp_eff != DW'(1)) && (degc_q != DW'(1)) &&
              (nonleaf_q < bgf_pkg::TotalCap)) begin
            nonleaf_d = nonleaf_q + SW'(1);
          end
        end
        lt_re   = 1'b1;
        lt_ra   = top_q.node;
        state_d = bgf_pkg::StPopMin;
      end

      bgf_pkg::StPopMin: begin
        cmp_a = lowc_q;
        cmp_b = lt_rd;
        if (cmp_lt) begin
          lt_we = 1'b1;
          lt_wa = top_q.node;
          lt_wd = cmp_min;
        end
        state_d = bpend_q ? bgf_pkg::StEmit : bgf_pkg::StStep;
      end

      bgf_pkg::StEmit: begin
        cmp_a = {1'b0, top_q.node};
        cmp_b = {1'b0, child_q};
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          rec_kind_d  = bgf_pkg::KindBridge;
          rec_lo_d    = cmp_lt ? top_q.node : child_q;
          rec_hi_d    = cmp_lt ? child_q : top_q.node;
          state_d     = bgf_pkg::StStep;
        end
      end

      bgf_pkg::StTotals: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          rec_kind_d  = bgf_pkg::KindTotals;
          rec_bt_d    = bridges_q;
          rec_nt_d    = nonleaf_q;
          rec_drop_d  = drop_q;
          rec_last_d  = 1'b1;
          // The graph store empties by dropping every list at once.
          vused_d     = '0;
          used_d      = '0;
          drop_d      = 1'b0;
          state_d     = bgf_pkg::StIdle;
        end
      end

      default: begin
        state_d = bgf_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bgf_pkg::StIdle;
      used_q      <= '0;
      drop_q      <= 1'b0;
      vused_q     <= '0;
      visited_q   <= '0;
      n_q         <= '0;
      root_q      <= '0;
      vc_q        <= '0;
      sp_q        <= '0;
      bridges_q   <= '0;
      nonleaf_q   <= '0;
      out_valid_q <= 1'b0;
      bpend_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      drop_q      <= drop_d;
      vused_q     <= vused_d;
      visited_q   <= visited_d;
      n_q         <= n_d;
      root_q      <= root_d;
      vc_q        <= vc_d;
      sp_q        <= sp_d;
      bridges_q   <= bridges_d;
      nonleaf_q   <= nonleaf_d;
      out_valid_q <= out_valid_d;
      bpend_q     <= bpend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q   <= top_d;
    ld_v_q  <= ld_v_d;
    ld_w_q  <= ld_w_d;
    nv_q    <= nv_d;
    npar_q  <= npar_d;
    nhp_q   <= nhp_d;
    child_q <= child_d;
    degc_q  <= degc_d;
    lowc_q  <= lowc_d;
    if (out_load) begin
      rec_kind_q <= rec_kind_d;
      rec_lo_q   <= rec_lo_d;
      rec_hi_q   <= rec_hi_d;
      rec_bt_q   <= rec_bt_d;
      rec_nt_q   <= rec_nt_d;
      rec_drop_q <= rec_drop_d;
      rec_last_q <= rec_last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = rec_kind_q;
  assign end_low_o       = rec_lo_q;
  assign end_high_o      = rec_hi_q;
  assign bridge_total_o  = rec_bt_q;
  assign nonleaf_total_o = rec_nt_q;
  assign dropped_o       = rec_drop_q;
  assign last_o          = rec_last_q;

  // The visit clock always equals the number of vertices visited in this run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q == TW'($countones(visited_q)))
    else $error("visit clock out of step with visited vertices");

  // Every stacked frame belongs to a distinct visited vertex.
  assert property (@(posedge clk_i) disable iff (!rst_ni) sp_q <= vc_q)
    else $error("walk stack deeper than visited vertex count");

  // A bridge transaction always carries its endpoints in ascending order.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == bgf_pkg::KindBridge)) |-> (end_low_o < end_high_o))
    else $error("bridge endpoints not ordered");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for graph_bridge_finder_unit: random graphs, bridge prediction.
`timescale 1ns / 1ps
module tb_top;

  typedef struct {
    logic       op;
    logic [5:0] vtx;
    logic [5:0] nbr;
    logic [6:0] cnt;
    bit         sync;   // hold this transaction back until all results are in
  } stim_t;

  typedef struct {
    logic       kind;
    logic [5:0] lo;
    logic [5:0] hi;
    logic [5:0] btot;
    logic [5:0] ntot;
    logic       drop;
    logic       last;
  } rec_t;

  logic       clk_i, rst_ni;
  logic       in_valid_i, in_ready_o, operation_i;
  logic [5:0] vertex_i, neighbor_i;
  logic [6:0] vertex_count_i;
  logic       out_valid_o, out_ready_i, kind_o, dropped_o, last_o;
  logic [5:0] end_low_o, end_high_o, bridge_total_o, nonleaf_total_o;

  graph_bridge_finder_unit u_top (.*);

  stim_t pending_q[$];
  rec_t  expected_q[$];
  stim_t cur;
  int    errors = 0;
  int    cycle = 0;
  int    runs_done = 0;
  int    bridges_seen = 0;
  bit    in_acc = 0;

  // Shadow copy of the graph store, at the block's widths.
  logic [bgf_pkg::PtrW-1:0]  g_head[bgf_pkg::MaxVertices];
  logic [bgf_pkg::PtrW-1:0]  g_tail[bgf_pkg::MaxVertices];
  logic [bgf_pkg::DegW-1:0]  g_deg[bgf_pkg::MaxVertices];
  logic [bgf_pkg::VtxW-1:0]  g_target[bgf_pkg::MaxEntries];
  logic [bgf_pkg::PtrW-1:0]  g_link[bgf_pkg::MaxEntries];
  logic [bgf_pkg::PtrW-1:0]  g_used;
  logic                      g_drop;
  logic [bgf_pkg::TimeW-1:0] t_entry[bgf_pkg::MaxVertices];
  logic [bgf_pkg::TimeW-1:0] t_low[bgf_pkg::MaxVertices];
  bgf_pkg::frame_t           walk[bgf_pkg::MaxVertices];

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_store();
    for (int i = 0; i < bgf_pkg::MaxVertices; i++) begin
      g_head[i] = bgf_pkg::NoEntry;
      g_tail[i] = bgf_pkg::NoEntry;
      g_deg[i]  = '0;
    end
    g_used = '0;
    g_drop = 1'b0;
  endfunction

  function automatic void append_entry(logic [5:0] v, logic [5:0] w);
    if (g_used >= bgf_pkg::MaxEntries) begin
      g_drop = 1'b1;
      return;
    end
    g_target[g_used] = w;
    g_link[g_used] = bgf_pkg::NoEntry;
    if (g_tail[v] == bgf_pkg::NoEntry) g_head[v] = g_used;
    else g_link[g_tail[v]] = g_used;
    g_tail[v] = g_used;
    g_deg[v]++;
    g_used++;
  endfunction

  // Iterative depth-first walk with low-link times; queues bridge and totals records.
  task automatic predict_bridges(logic [6:0] count_in);
    int   n, depth, clk_t, nb, nn;
    int   c, p, e, w, v;
    rec_t r;
    n = (count_in > bgf_pkg::MaxVertices) ? bgf_pkg::MaxVertices : count_in;
    depth = 0;
    clk_t = 0;
    nb = 0;
    nn = 0;
    for (int i = 0; i < bgf_pkg::MaxVertices; i++) t_entry[i] = '0;
    for (int root = 0; root < n; root++) begin
      if (t_entry[root] != 0) continue;
      clk_t++;
      t_entry[root] = clk_t;
      t_low[root] = clk_t;
      walk[0] = '{node: root, parent: '0, has_parent: 1'b0, cursor: g_head[root]};
      depth = 1;
      while (depth > 0) begin
        e = walk[depth-1].cursor;
        if (e >= bgf_pkg::MaxEntries) begin
          c = walk[depth-1].node;
          depth--;
          if (depth > 0) begin
            p = walk[depth-1].node;
            if (t_low[c] > t_entry[p]) begin
              // Endpoint records stop at 63 with the totals saturating there too.
              if (nb < bgf_pkg::TotalCap) begin
                nb++;
                r = '{bgf_pkg::KindBridge, (p < c) ? p : c, (p < c) ? c : p,
                      '0, '0, 1'b0, 1'b0};
                expected_q.push_back(r);
              end
              if (g_deg[p] != 1 && g_deg[c] != 1 && nn < bgf_pkg::TotalCap) nn++;
            end
            if (t_low[c] < t_low[p]) t_low[p] = t_low[c];
          end
          continue;
        end
        walk[depth-1].cursor = g_link[e];
        w = g_target[e];
        v = walk[depth-1].node;
        if (w >= n) continue;
        // Every entry back to the parent is ignored, parallel ones included.
        if (walk[depth-1].has_parent && w == walk[depth-1].parent) continue;
        if (t_entry[w] == 0) begin
          clk_t++;
          t_entry[w] = clk_t;
          t_low[w] = clk_t;
          walk[depth] = '{node: w, parent: v, has_parent: 1'b1, cursor: g_head[w]};
          depth++;
        end else if (t_entry[w] < t_low[v]) begin
          t_low[v] = t_entry[w];
        end
      end
    end
    r = '{bgf_pkg::KindTotals, '0, '0, nb, nn, g_drop, 1'b1};
    expected_q.push_back(r);
    clear_store();
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("tb_top: mismatch at cycle %0d: %s got %0d want %0d", cycle, what, got, want);
    errors++;
  endtask

  // Stimulus builders.
  function automatic void add_load(int v, int w, bit sync = 0);
    stim_t s;
    s = '{bgf_pkg::OpLoad, v[5:0], w[5:0], $urandom, sync};
    pending_q.push_back(s);
  endfunction

  function automatic void add_run(int n, bit sync = 0);
    stim_t s;
    s = '{bgf_pkg::OpRun, $urandom, $urandom, n[6:0], sync};
    pending_q.push_back(s);
  endfunction

  function automatic void add_edge(int a, int b);
    add_load(a, b);
    add_load(b, a);
  endfunction

  // A random forest over a small vertex range, with a few cycles, self loops,
  // parallel and one-way entries mixed in, then a run.
  function automatic void add_graph(int n, int base, bit sync);
    int extra;
    add_load(base, base + (n > 1 ? 1 : 0), sync);
    for (int i = 1; i < n; i++)
      if ($urandom_range(0, 9) != 0) add_edge(base + i, base + $urandom_range(0, i - 1));
    extra = $urandom_range(0, 3);
    for (int k = 0; k < extra; k++) begin
      case ($urandom_range(0, 3))
        0: add_edge(base + $urandom_range(0, n - 1), base + $urandom_range(0, n - 1));
        1: add_load(base + $urandom_range(0, n - 1), base + $urandom_range(0, n - 1));
        2: add_load(base + $urandom_range(0, n - 1), $urandom_range(0, 63));
        default: add_load($urandom_range(0, 63), $urandom_range(0, 63));
      endcase
    end
    case ($urandom_range(0, 9))
      0: add_run($urandom_range(0, 127));
      1: add_run(base + $urandom_range(0, n));
      default: add_run(base + n);
    endcase
  endfunction

  initial begin
    // Directed: extreme ids, parallel edges to a parent, empty and oversized counts.
    add_edge(0, 1);
    add_edge(63, 62);
    add_load(62, 63);
    add_edge(62, 61);
    add_load(5, 63);
    add_run(64);
    add_run(0, 1);
    add_edge(0, 1);
    add_edge(1, 2);
    add_edge(2, 0);
    add_edge(2, 3);
    add_run(127);
    add_edge(0, 1);
    add_run(1);
    // A 64-vertex path gives the most bridges a run can hold. Its edges are then
    // repeated, which keeps every bridge, until the entry store overflows.
    for (int i = 0; i < 63; i++) add_edge(i, i + 1);
    for (int i = 0; i < 66; i++) add_edge(i % 63, i % 63 + 1);
    add_run(64, 1);
    while (pending_q.size() < 300)
      add_graph($urandom_range(1, 12), $urandom_range(0, 50), $urandom_range(0, 5) == 0);
  end

  // Acceptance and prediction at the rising edge.
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    in_acc <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) begin
      if (cur.op == bgf_pkg::OpLoad) append_entry(cur.vtx, cur.nbr);
      else begin
        predict_bridges(cur.cnt);
        runs_done++;
      end
    end
  end

  function automatic bit calm();
    return cycle > 1500 && cycle < 3000;
  endfunction

  // Sender: one transaction held until accepted, random gaps, sync points.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_acc) begin
      if (pending_q.size() == 0) in_valid_i <= 1'b0;
      else if (pending_q[0].sync && expected_q.size() != 0) in_valid_i <= 1'b0;
      else if (!calm() && $urandom_range(0, 99) < 38) in_valid_i <= 1'b0;
      else begin
        cur = pending_q.pop_front();
        in_valid_i <= 1'b1;
        operation_i <= cur.op;
        vertex_i <= cur.vtx;
        neighbor_i <= cur.nbr;
        vertex_count_i <= cur.cnt;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off during the long path search.
  int  hold_left = 0;
  bit  hold_done = 0;
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (!hold_done && out_valid_o && runs_done >= 5) begin
      hold_done <= 1;
      hold_left <= 400;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm() || $urandom_range(0, 99) >= 38;
    end
  end

  // Result checking against the oldest expectation.
  always @(posedge clk_i) begin
    rec_t x;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected record kind", kind_o, -1);
      end else begin
        x = expected_q.pop_front();
        if (kind_o !== x.kind) report_mismatch("kind", kind_o, x.kind);
        if (end_low_o !== x.lo) report_mismatch("end_low", end_low_o, x.lo);
        if (end_high_o !== x.hi) report_mismatch("end_high", end_high_o, x.hi);
        if (bridge_total_o !== x.btot) report_mismatch("bridge_total", bridge_total_o, x.btot);
        if (nonleaf_total_o !== x.ntot)
          report_mismatch("nonleaf_total", nonleaf_total_o, x.ntot);
        if (dropped_o !== x.drop) report_mismatch("dropped", dropped_o, x.drop);
        if (last_o !== x.last) report_mismatch("last", last_o, x.last);
        if (x.kind == bgf_pkg::KindBridge) bridges_seen++;
      end
    end
  end

  // Watchdog on cycles without any transaction on either side.
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 30000) begin
      $display("tb_top: stalled, %0d records outstanding", expected_q.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = 1'b0;
    vertex_i = '0;
    neighbor_i = '0;
    vertex_count_i = '0;
    out_ready_i = 1'b0;
    clear_store();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (pending_q.size() == 0 && !in_valid_i);
    wait (expected_q.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("tb_top: %0d searches run, %0d bridge records checked, %0d cycles",
             runs_done, bridges_seen, cycle);
    if (errors == 0 && expected_q.size() == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
